// ===== hdl/eats_pkg.sv =====
// Shared types, character codes and helpers for the escape-aware token splitter.
// No dependencies; used by eats_decode, eats_emit and escape_aware_token_splitter.
`timescale 1ns / 1ps

package eats_pkg;

   // Most results a single request can produce
   localparam int MaxRes = 7;
   // Most decoded bytes a single request can produce (expanded control escape)
   localparam int MaxCand = 6;

   // Character codes
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChQuote     = 8'h22;
   localparam logic [7:0] ChQmark     = 8'h3F;
   localparam logic [7:0] ChZero      = 8'h30;
   localparam logic [7:0] ChNine      = 8'h39;
   localparam logic [7:0] ChLbracket  = 8'h5B;
   localparam logic [7:0] ChRbracket  = 8'h5D;
   localparam logic [7:0] ChLowerX    = 8'h78;

   // Escape letters
   localparam logic [7:0] EscN = 8'h6E;
   localparam logic [7:0] EscT = 8'h74;
   localparam logic [7:0] EscV = 8'h76;
   localparam logic [7:0] EscB = 8'h62;
   localparam logic [7:0] EscR = 8'h72;
   localparam logic [7:0] EscF = 8'h66;
   localparam logic [7:0] EscA = 8'h61;

   // Control bytes they stand for
   localparam logic [7:0] CtlNewline  = 8'h0A;
   localparam logic [7:0] CtlTab      = 8'h09;
   localparam logic [7:0] CtlVtab     = 8'h0B;
   localparam logic [7:0] CtlBackspc  = 8'h08;
   localparam logic [7:0] CtlReturn   = 8'h0D;
   localparam logic [7:0] CtlFormfeed = 8'h0C;
   localparam logic [7:0] CtlBell     = 8'h07;

   // Register indexes on the csr port
   localparam logic [1:0] RegSep0 = 2'd0;
   localparam logic [1:0] RegSep1 = 2'd1;
   localparam logic [1:0] RegSep2 = 2'd2;
   localparam logic [1:0] RegSep3 = 2'd3;

   // Reset value of the low separator word: space only
   localparam logic [63:0] Sep0Reset = 64'h0000_0001_0000_0000;

   // One result item
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       tend;
   } res_type;

   // All results caused by one request
   typedef struct packed {
      res_type [MaxRes-1:0] item;
      logic [2:0]           count;
      logic                 stream_end;
   } batch_type;

   // Upper-case hex digit text for a nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'd0, nib};
      if (nib < 4'd10) return ChZero + wide;
      else return 8'd55 + wide;
   endfunction

endpackage

// ===== hdl/eats_decode.sv =====
// Escape decoder and token tracker: separator bitmap, escape state, result batch build.
// Depends on eats_pkg.
`timescale 1ns / 1ps

module eats_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_wdata,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   input  logic                fire,
   output eats_pkg::batch_type batch
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ESC,
      PH_OCT1,
      PH_OCT2
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [7:0]    accum_ff, accum_in;
   logic          open_ff, open_in;
   logic [63:0]   sep0_ff, sep1_ff, sep2_ff, sep3_ff;
   logic [255:0]  sep_map;

   assign sep_map = {sep3_ff, sep2_ff, sep1_ff, sep0_ff};

   // Decode the byte into up to six candidate bytes, then split against the bitmap
   always_comb begin
      logic [7:0] cand [eats_pkg::MaxCand];
      logic [2:0] ncand;
      logic [7:0] code;
      logic       ctrl;
      logic [7:0] oct;
      logic [2:0] k;
      logic       open_v;
      for (int i = 0; i < eats_pkg::MaxCand; i++) cand[i] = 8'd0;
      ncand    = 3'd0;
      code     = 8'd0;
      ctrl     = 1'b0;
      oct      = {accum_ff[4:0], 3'b000} + (in_byte - eats_pkg::ChZero);
      phase_in = phase_ff;
      accum_in = accum_ff;

      case (phase_ff)
         PH_ESC: begin
            phase_in = PH_IDLE;
            case (in_byte)
               eats_pkg::EscN: begin ctrl = 1'b1; code = eats_pkg::CtlNewline; end
               eats_pkg::EscT: begin ctrl = 1'b1; code = eats_pkg::CtlTab; end
               eats_pkg::EscV: begin ctrl = 1'b1; code = eats_pkg::CtlVtab; end
               eats_pkg::EscB: begin ctrl = 1'b1; code = eats_pkg::CtlBackspc; end
               eats_pkg::EscR: begin ctrl = 1'b1; code = eats_pkg::CtlReturn; end
               eats_pkg::EscF: begin ctrl = 1'b1; code = eats_pkg::CtlFormfeed; end
               eats_pkg::EscA: begin ctrl = 1'b1; code = eats_pkg::CtlBell; end
               eats_pkg::ChBackslash: begin cand[0] = eats_pkg::ChBackslash; ncand = 3'd1; end
               eats_pkg::ChQuote: begin cand[0] = eats_pkg::ChQmark; ncand = 3'd1; end
               default: begin
                  if (in_byte inside {[eats_pkg::ChZero:eats_pkg::ChNine]}) begin
                     accum_in = in_byte - eats_pkg::ChZero;
                     phase_in = PH_OCT1;
                  end else begin
                     cand[0] = in_byte;
                     ncand   = 3'd1;
                  end
               end
            endcase
         end
         PH_OCT1: begin
            accum_in = oct;
            phase_in = PH_OCT2;
         end
         PH_OCT2: begin
            cand[0]  = oct;
            ncand    = 3'd1;
            accum_in = 8'd0;
            phase_in = PH_IDLE;
         end
         default: begin
            if (in_byte == eats_pkg::ChBackslash) begin
               phase_in = PH_ESC;
            end else begin
               cand[0] = in_byte;
               ncand   = 3'd1;
            end
         end
      endcase

      // Control escape: the byte itself if it separates, else its [0xNN] text
      if (ctrl) begin
         if (sep_map[code]) begin
            cand[0] = code;
            ncand   = 3'd1;
         end else begin
            cand[0] = eats_pkg::ChLbracket;
            cand[1] = eats_pkg::ChZero;
            cand[2] = eats_pkg::ChLowerX;
            cand[3] = eats_pkg::hex_char(code[7:4]);
            cand[4] = eats_pkg::hex_char(code[3:0]);
            cand[5] = eats_pkg::ChRbracket;
            ncand   = 3'd6;
         end
      end

      // Split candidates into token bytes and token-end markers
      batch  = '0;
      k      = 3'd0;
      open_v = open_ff;
      for (int i = 0; i < eats_pkg::MaxCand; i++) begin
         if (3'(i) < ncand) begin
            if (sep_map[cand[i]]) begin
               if (open_v) begin
                  batch.item[k] = '{data: 8'd0, valid: 1'b0, tend: 1'b1};
                  k      = k + 3'd1;
                  open_v = 1'b0;
               end
            end else begin
               batch.item[k] = '{data: cand[i], valid: 1'b1, tend: 1'b0};
               k      = k + 3'd1;
               open_v = 1'b1;
            end
         end
      end

      // End of string closes the token and resets the escape state
      if (in_last) begin
         if (open_v) begin
            batch.item[k] = '{data: 8'd0, valid: 1'b0, tend: 1'b1};
            k = k + 3'd1;
         end
         if (k == 3'd0) begin
            batch.item[0] = '0;
            k = 3'd1;
         end
         open_v           = 1'b0;
         phase_in         = PH_IDLE;
         accum_in         = 8'd0;
         batch.stream_end = 1'b1;
      end
      batch.count = k;
      open_in     = open_v;
   end

   // State and separator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         accum_ff <= 8'd0;
         open_ff  <= 1'b0;
         sep0_ff  <= eats_pkg::Sep0Reset;
         sep1_ff  <= 64'd0;
         sep2_ff  <= 64'd0;
         sep3_ff  <= 64'd0;
      end else begin
         if (fire) begin
            phase_ff <= phase_in;
            accum_ff <= accum_in;
            open_ff  <= open_in;
         end
         if (csr_we) begin
            case (csr_index)
               eats_pkg::RegSep0: sep0_ff <= csr_wdata;
               eats_pkg::RegSep1: sep1_ff <= csr_wdata;
               eats_pkg::RegSep2: sep2_ff <= csr_wdata;
               eats_pkg::RegSep3: sep3_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== hdl/eats_emit.sv =====
// Result stage: holds one batch of results and hands them out one per cycle while rsp_tready is high.
// Depends on eats_pkg.
`timescale 1ns / 1ps

module eats_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  eats_pkg::batch_type batch,
   output logic                free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic [2:0]          rsp_tuser,
   output logic                rsp_tlast
);

   eats_pkg::res_type [eats_pkg::MaxRes-1:0] item_ff;
   logic [2:0] count_ff;
   logic [2:0] idx_ff;
   logic       stream_ff;
   logic       take;
   logic       final_item;
   eats_pkg::res_type cur;

   assign cur        = item_ff[idx_ff];
   assign final_item = (idx_ff == count_ff - 3'd1);
   assign rsp_tvalid = (count_ff != 3'd0);
   assign take       = rsp_tvalid && rsp_tready;
   assign free       = !rsp_tvalid || (take && final_item);

   assign rsp_tdata = cur.data;
   assign rsp_tuser = {stream_ff && final_item, cur.tend, cur.valid};
   assign rsp_tlast = final_item;

   // Payload of the batch
   always_ff @(posedge clock) begin
      if (load && batch.count != 3'd0) begin
         item_ff   <= batch.item;
         stream_ff <= batch.stream_end;
      end
   end

   // Count and read pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         idx_ff   <= 3'd0;
      end else if (load) begin
         count_ff <= batch.count;
         idx_ff   <= 3'd0;
      end else if (take && final_item) begin
         count_ff <= 3'd0;
         idx_ff   <= 3'd0;
      end else if (take) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

endmodule

// ===== hdl/escape_aware_token_splitter.sv =====
// Top level of the escape-aware token splitter: request register, decoder, result stage.
// Depends on eats_pkg, eats_decode and eats_emit.
// A taken request waits in the request register until the result stage is free; its
// results are then registered in the result stage, which offers the first of them.
// Throughput: one request per cycle while each gives at most one result and rsp_tready is
// high; N results hold the result stage till taken (up to 7, for an expanded escape).
// Reset: synchronous; clears escape state, open token and pending results, and sets the
// separator bitmap to space only. No clearing pass.
`timescale 1ns / 1ps

module escape_aware_token_splitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [2:0]  rsp_tuser,   // [0] byte_valid, [1] token_end, [2] stream_end
   output logic        rsp_tlast    // run_last
);

   logic                valid_ff;
   logic [7:0]          byte_ff;
   logic                last_ff;
   logic                free;
   logic                fire;
   eats_pkg::batch_type batch;

   assign fire       = valid_ff && free;
   assign req_tready = !valid_ff || fire;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         valid_ff <= 1'b1;
      end else if (fire) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   eats_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_byte   (byte_ff),
      .in_last   (last_ff),
      .fire      (fire),
      .batch     (batch)
   );

   eats_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .batch      (batch),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== dv/escape_aware_token_splitter_test.sv =====
// Self-checking bench for escape_aware_token_splitter: predicts the token stream of
// each request and compares every result on the rsp side. Depends on eats_pkg.
`timescale 1ns / 1ps

module escape_aware_token_splitter_test;

   // One expected token-stream result
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       tend;
      logic       run_last;
      logic       strm_end;
   } tok_out_type;

   typedef enum logic [1:0] {PhIdle, PhEsc, PhOct1, PhOct2} esc_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = eats_pkg::RegSep0;
   logic [63:0] csr_wdata = 64'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   // Separator map and escape state as the block should hold them
   logic [255:0]  sep_map = {192'd0, eats_pkg::Sep0Reset};
   esc_phase_type esc_phase = PhIdle;
   logic [7:0]    oct_acc = 8'd0;
   logic          tok_open = 1'b0;

   tok_out_type  batch[$];
   tok_out_type  expected_tokens[$];
   logic [7:0]   text_q[$];
   logic [7:0]   ctl_letters[7] = '{eats_pkg::EscN, eats_pkg::EscT, eats_pkg::EscV,
                                    eats_pkg::EscB, eats_pkg::EscR, eats_pkg::EscF,
                                    eats_pkg::EscA};

   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_req = 0;
   int hold_left = 0;

   escape_aware_token_splitter uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] in_byte
      .req_tlast  (req_tlast),   // is_last
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] out_byte
      .rsp_tuser  (rsp_tuser),   // [0] byte_valid, [1] token_end, [2] stream_end
      .rsp_tlast  (rsp_tlast)    // run_last
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------- token prediction ----------------

   function automatic void emit_result(input logic [7:0] b, input logic v, input logic e);
      tok_out_type r;
      r.data = b;
      r.valid = v;
      r.tend = e;
      r.run_last = 1'b0;
      r.strm_end = 1'b0;
      batch.push_back(r);
   endfunction

   // Separator closes an open token; anything else is a token byte
   function automatic void classify(input logic [7:0] b);
      if (sep_map[b]) begin
         if (tok_open) begin
            emit_result(8'h00, 1'b0, 1'b1);
            tok_open = 1'b0;
         end
      end else begin
         emit_result(b, 1'b1, 1'b0);
         tok_open = 1'b1;
      end
   endfunction

   function automatic logic [7:0] nibble_text(input logic [3:0] n);
      if (n < 4'd10) return eats_pkg::ChZero + {4'd0, n};
      return 8'h41 + {4'd0, n} - 8'd10;
   endfunction

   // Control byte passes as is when it separates, else becomes "[0xNN]"
   function automatic void expand_control(input logic [7:0] code);
      if (sep_map[code]) begin
         classify(code);
      end else begin
         classify(eats_pkg::ChLbracket);
         classify(eats_pkg::ChZero);
         classify(eats_pkg::ChLowerX);
         classify(nibble_text(code[7:4]));
         classify(nibble_text(code[3:0]));
         classify(eats_pkg::ChRbracket);
      end
   endfunction

   function automatic void after_backslash(input logic [7:0] c);
      esc_phase = PhIdle;
      case (c)
         eats_pkg::EscN: expand_control(eats_pkg::CtlNewline);
         eats_pkg::EscT: expand_control(eats_pkg::CtlTab);
         eats_pkg::EscV: expand_control(eats_pkg::CtlVtab);
         eats_pkg::EscB: expand_control(eats_pkg::CtlBackspc);
         eats_pkg::EscR: expand_control(eats_pkg::CtlReturn);
         eats_pkg::EscF: expand_control(eats_pkg::CtlFormfeed);
         eats_pkg::EscA: expand_control(eats_pkg::CtlBell);
         eats_pkg::ChBackslash: classify(eats_pkg::ChBackslash);
         eats_pkg::ChQuote: classify(eats_pkg::ChQmark);
         default: begin
            if (c >= eats_pkg::ChZero && c <= eats_pkg::ChNine) begin
               oct_acc = c - eats_pkg::ChZero;
               esc_phase = PhOct1;
            end else begin
               // unknown escape: backslash dropped
               classify(c);
            end
         end
      endcase
   endfunction

   function automatic void predict_tokens(input logic [7:0] c, input logic last);
      batch.delete();
      case (esc_phase)
         PhEsc: after_backslash(c);
         PhOct1: begin
            oct_acc = oct_acc * 8'd8 + (c - eats_pkg::ChZero);
            esc_phase = PhOct2;
         end
         PhOct2: begin
            oct_acc = oct_acc * 8'd8 + (c - eats_pkg::ChZero);
            esc_phase = PhIdle;
            classify(oct_acc);
            oct_acc = 8'd0;
         end
         default: begin
            if (c == eats_pkg::ChBackslash) esc_phase = PhEsc;
            else classify(c);
         end
      endcase
      // end of string: close token, drop pending escape, mark the end
      if (last) begin
         if (tok_open) emit_result(8'h00, 1'b0, 1'b1);
         if (batch.size() == 0) emit_result(8'h00, 1'b0, 1'b0);
         esc_phase = PhIdle;
         oct_acc = 8'd0;
         tok_open = 1'b0;
         batch[batch.size() - 1].strm_end = 1'b1;
      end
      if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
      foreach (batch[i]) expected_tokens.push_back(batch[i]);
   endfunction

   // Predict on every accepted request
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) predict_tokens(req_tdata, req_tlast);
   end

   // ---------------- result checking ----------------

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      tok_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch("result with nothing pending", int'(rsp_tdata), 0);
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_tdata !== want.data)
               report_mismatch("out_byte", int'(rsp_tdata), int'(want.data));
            if (rsp_tuser[0] !== want.valid)
               report_mismatch("byte_valid", int'(rsp_tuser[0]), int'(want.valid));
            if (rsp_tuser[1] !== want.tend)
               report_mismatch("token_end", int'(rsp_tuser[1]), int'(want.tend));
            if (rsp_tlast !== want.run_last)
               report_mismatch("run_last", int'(rsp_tlast), int'(want.run_last));
            if (rsp_tuser[2] !== want.strm_end)
               report_mismatch("stream_end", int'(rsp_tuser[2]), int'(want.strm_end));
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off counted here on request
   always @(posedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------- stimulus helpers ----------------

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
   endtask

   // Let every pending result drain, then allow for requests still in flight
   task automatic wait_idle();
      int spins;
      spins = 0;
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0 && spins < 5000) begin
         @(posedge clock);
         spins++;
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic load_separators(input logic [255:0] map);
      wait_idle();
      write_reg(eats_pkg::RegSep0, map[63:0]);
      write_reg(eats_pkg::RegSep1, map[127:64]);
      write_reg(eats_pkg::RegSep2, map[191:128]);
      write_reg(eats_pkg::RegSep3, map[255:192]);
      csr_we <= 1'b0;
      sep_map = map;
   endtask

   function automatic logic [255:0] typical_seps();
      logic [255:0] m;
      m = '0;
      m[8'h20] = 1'b1;
      m[eats_pkg::CtlTab] = 1'b1;
      m[eats_pkg::CtlNewline] = 1'b1;
      m[8'h2C] = 1'b1;
      m[eats_pkg::ChLowerX] = 1'b1;
      m[8'hA0] = 1'b1;
      m[8'hFF] = 1'b1;
      return m;
   endfunction

   // One random piece of text: plain or separator bytes, escapes of every kind, or a zero byte
   task automatic add_segment();
      int k;
      k = $urandom_range(99);
      if (k < 30) begin
         text_q.push_back(8'($urandom_range(8'h7E, 8'h21)));
      end else if (k < 40) begin
         case ($urandom_range(4))
            0: text_q.push_back(8'h20);
            1: text_q.push_back(eats_pkg::CtlTab);
            2: text_q.push_back(8'h2C);
            3: text_q.push_back(eats_pkg::CtlNewline);
            default: text_q.push_back(8'hA0);
         endcase
      end else if (k < 62) begin
         text_q.push_back(eats_pkg::ChBackslash);
         text_q.push_back(ctl_letters[$urandom_range(6)]);
      end else if (k < 70) begin
         text_q.push_back(eats_pkg::ChBackslash);
         text_q.push_back($urandom_range(1) ? eats_pkg::ChBackslash : eats_pkg::ChQuote);
      end else if (k < 82) begin
         text_q.push_back(eats_pkg::ChBackslash);
         text_q.push_back(eats_pkg::ChZero + 8'($urandom_range(9)));
         repeat (2) begin
            if ($urandom_range(4) == 0) text_q.push_back(8'($urandom_range(255)));
            else text_q.push_back(eats_pkg::ChZero + 8'($urandom_range(7)));
         end
      end else if (k < 88) begin
         text_q.push_back(eats_pkg::ChBackslash);
         text_q.push_back(8'($urandom_range(255)));
      end else if (k < 93) begin
         text_q.push_back(8'h00);
      end else begin
         text_q.push_back(8'($urandom_range(255)));
      end
   endtask

   // Random strings until about n requests went out
   task automatic send_random_strings(input int n);
      int sent;
      int pieces;
      sent = 0;
      while (sent < n) begin
         text_q.delete();
         if ($urandom_range(9) == 0) begin
            // raw noise
            repeat ($urandom_range(6, 1)) text_q.push_back(8'($urandom_range(255)));
         end else begin
            pieces = $urandom_range(6, 1);
            repeat (pieces) add_segment();
            // escape cut off by the end of the string
            if ($urandom_range(9) == 0) begin
               text_q.push_back(eats_pkg::ChBackslash);
               repeat ($urandom_range(2))
                  text_q.push_back(eats_pkg::ChZero + 8'($urandom_range(7)));
            end
         end
         send_text();
         sent += text_q.size();
      end
   endtask

   // ---------------- tests ----------------

   // Zero byte, top byte value and a separator with reset separators
   task automatic test_plain_bytes();
      text_q = '{8'h00, 8'h20, 8'hFF};
      send_text();
   endtask

   // Every control escape; tab, return and form feed separate, the rest expand
   task automatic test_control_escapes();
      logic [255:0] m;
      m = '0;
      m[8'h20] = 1'b1;
      m[eats_pkg::CtlTab] = 1'b1;
      m[eats_pkg::CtlReturn] = 1'b1;
      m[eats_pkg::CtlFormfeed] = 1'b1;
      load_separators(m);
      text_q.delete();
      foreach (ctl_letters[i]) begin
         text_q.push_back(eats_pkg::ChBackslash);
         text_q.push_back(ctl_letters[i]);
      end
      send_text();
   endtask

   // Backslash, quote, unknown escape, octal wrap, non-digit octal digits, cut-off escape
   task automatic test_special_escapes();
      text_q = '{eats_pkg::ChBackslash, eats_pkg::ChBackslash, eats_pkg::ChBackslash,
                 eats_pkg::ChQuote, eats_pkg::ChBackslash, 8'h71,
                 eats_pkg::ChBackslash, 8'h37, 8'h37, 8'h37, eats_pkg::ChBackslash,
                 eats_pkg::ChNine, 8'h7A, 8'h41, 8'h20, eats_pkg::ChBackslash};
      send_text();
   endtask

   task automatic test_random_text(input logic [255:0] map, input int send_pct,
                                   input int stall_pct, input int n);
      load_separators(map);
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      send_random_strings(n);
   endtask

   // Receiver holds off while the sender keeps going, so the input must stall
   task automatic test_backpressure();
      load_separators(typical_seps());
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req = 120;
      send_random_strings(12);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_plain_bytes();
      test_control_escapes();
      test_special_escapes();
      test_random_text('0, 0, 0, 12);
      test_random_text('1, 46, 0, 12);
      test_random_text(typical_seps(), 0, 46, 12);
      test_random_text({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom}, 22, 22, 12);
      test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_idle();
      if (expected_tokens.size() != 0)
         report_mismatch("results never delivered", 0, expected_tokens.size());
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #3000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
